/* src/qfs_pkg.sv */
`default_nettype none

package qfs_pkg;

    // Character codes the parser reacts to.
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_MANY    = 3'd1;
    localparam logic [2:0] ST_BAD_ESCAPE  = 3'd2;
    localparam logic [2:0] ST_UNTERM      = 3'd3;
    localparam logic [2:0] ST_EMPTY_QUOTE = 3'd4;
    localparam logic [2:0] ST_NO_SPACE    = 3'd5;

    // Configuration register indexes and reset values.
    localparam logic       REG_MAX_FIELDS   = 1'b0;
    localparam logic [7:0] MAX_FIELDS_RESET = 8'd8;

    // Command queue between parser and output stage.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        MODE_BETWEEN,
        MODE_BARE,
        MODE_QUOTED,
        MODE_ESCAPE,
        MODE_AFTER_QUOTE,
        MODE_COMMENT,
        MODE_DISCARD
    } t_mode;

    // One parser command: a result, optionally followed by a line-done
    // result whose total is field_index + 1.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_out;
        logic [7:0] field_index;
        logic [7:0] field_total;
        logic [2:0] status;
        logic       done_after;
    } t_cmd;

    // Queue status seen by the input handshake and the output stage.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

/* src/qfs_front.sv */
`default_nettype none

module qfs_front
    import qfs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_char,
    input  wire logic [7:0] i_max_fields,
    output logic            o_push,
    output t_cmd            o_cmd
);

    t_mode       r_mode;
    t_mode       n_mode;
    logic [7:0]  r_count;
    logic [7:0]  n_count;
    logic        r_has;
    logic        n_has;
    logic        emit;
    t_cmd        cmd;

    logic is_blank;
    logic is_nul;
    logic is_quote;
    logic is_bslash;
    logic over_limit;
    logic [7:0] count_inc;

    // Character classification.
    assign is_blank   = (i_char == CH_SPACE) || (i_char == CH_TAB);
    assign is_nul     = (i_char == CH_NUL);
    assign is_quote   = (i_char == CH_QUOTE);
    assign is_bslash  = (i_char == CH_BACKSLASH);
    assign over_limit = (r_count >= i_max_fields);
    assign count_inc  = r_count + 8'd1;

    // Next parse mode.
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_BETWEEN: begin
                if (is_blank) begin
                    n_mode = MODE_BETWEEN;
                end else if (i_char == CH_HASH) begin
                    n_mode = MODE_COMMENT;
                end else if (is_nul) begin
                    n_mode = MODE_BETWEEN;
                end else if (over_limit) begin
                    n_mode = MODE_DISCARD;
                end else if (is_quote) begin
                    n_mode = MODE_QUOTED;
                end else begin
                    n_mode = MODE_BARE;
                end
            end
            MODE_BARE, MODE_AFTER_QUOTE: begin
                if (is_blank || is_nul) begin
                    n_mode = MODE_BETWEEN;
                end else if (r_mode == MODE_AFTER_QUOTE) begin
                    n_mode = MODE_DISCARD;
                end
            end
            MODE_QUOTED: begin
                if (is_quote) begin
                    n_mode = r_has ? MODE_AFTER_QUOTE : MODE_DISCARD;
                end else if (is_bslash) begin
                    n_mode = MODE_ESCAPE;
                end else if (is_nul) begin
                    n_mode = MODE_BETWEEN;
                end
            end
            MODE_ESCAPE: begin
                if (is_quote || is_bslash) begin
                    n_mode = MODE_QUOTED;
                end else if (is_nul) begin
                    n_mode = MODE_BETWEEN;
                end else begin
                    n_mode = MODE_DISCARD;
                end
            end
            MODE_COMMENT: begin
                if (is_nul) begin
                    n_mode = MODE_BETWEEN;
                end
            end
            default: begin
                if (is_nul) begin
                    n_mode = MODE_BETWEEN;
                end
            end
        endcase
    end

    // Commands and counter updates.
    always_comb begin
        emit    = 1'b0;
        cmd     = '0;
        n_count = r_count;
        n_has   = r_has;
        case (r_mode)
            MODE_BETWEEN: begin
                if (is_blank || (i_char == CH_HASH)) begin
                    emit = 1'b0;
                end else if (is_nul) begin
                    emit            = 1'b1;
                    cmd.kind        = KIND_DONE;
                    cmd.field_total = r_count;
                    n_count         = '0;
                    n_has           = 1'b0;
                end else if (over_limit) begin
                    emit            = 1'b1;
                    cmd.kind        = KIND_ERROR;
                    cmd.field_index = r_count;
                    cmd.status      = ST_TOO_MANY;
                end else if (is_quote) begin
                    n_has = 1'b0;
                end else begin
                    emit            = 1'b1;
                    cmd.kind        = KIND_CHAR;
                    cmd.char_out    = i_char;
                    cmd.field_index = r_count;
                end
            end
            MODE_BARE, MODE_AFTER_QUOTE: begin
                if (is_blank || is_nul) begin
                    emit            = 1'b1;
                    cmd.kind        = KIND_END;
                    cmd.field_index = r_count;
                    n_count         = count_inc;
                    if (is_nul) begin
                        // Line ends right after the field: a line-done follows.
                        cmd.done_after  = 1'b1;
                        cmd.field_total = count_inc;
                        n_count         = '0;
                        n_has           = 1'b0;
                    end
                end else if (r_mode == MODE_BARE) begin
                    emit            = 1'b1;
                    cmd.kind        = KIND_CHAR;
                    cmd.char_out    = i_char;
                    cmd.field_index = r_count;
                end else begin
                    emit            = 1'b1;
                    cmd.kind        = KIND_ERROR;
                    cmd.field_index = r_count;
                    cmd.status      = ST_NO_SPACE;
                end
            end
            MODE_QUOTED: begin
                if (is_quote) begin
                    if (!r_has) begin
                        emit            = 1'b1;
                        cmd.kind        = KIND_ERROR;
                        cmd.field_index = r_count;
                        cmd.status      = ST_EMPTY_QUOTE;
                    end
                end else if (is_bslash) begin
                    emit = 1'b0;
                end else if (is_nul) begin
                    emit            = 1'b1;
                    cmd.kind        = KIND_ERROR;
                    cmd.field_index = r_count;
                    cmd.status      = ST_UNTERM;
                    n_count         = '0;
                    n_has           = 1'b0;
                end else begin
                    emit            = 1'b1;
                    cmd.kind        = KIND_CHAR;
                    cmd.char_out    = i_char;
                    cmd.field_index = r_count;
                    n_has           = 1'b1;
                end
            end
            MODE_ESCAPE: begin
                emit            = 1'b1;
                cmd.field_index = r_count;
                if (is_quote || is_bslash) begin
                    cmd.kind     = KIND_CHAR;
                    cmd.char_out = i_char;
                    n_has        = 1'b1;
                end else if (is_nul) begin
                    cmd.kind   = KIND_ERROR;
                    cmd.status = ST_UNTERM;
                    n_count    = '0;
                    n_has      = 1'b0;
                end else begin
                    cmd.kind   = KIND_ERROR;
                    cmd.status = ST_BAD_ESCAPE;
                end
            end
            MODE_COMMENT: begin
                if (is_nul) begin
                    emit            = 1'b1;
                    cmd.kind        = KIND_DONE;
                    cmd.field_total = r_count;
                    n_count         = '0;
                    n_has           = 1'b0;
                end
            end
            default: begin
                if (is_nul) begin
                    n_count = '0;
                    n_has   = 1'b0;
                end
            end
        endcase
    end

    assign o_push = i_accept && emit;
    assign o_cmd  = cmd;

    // Parser state, advanced once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_BETWEEN;
            r_count <= '0;
            r_has   <= 1'b0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_has   <= n_has;
        end
    end

endmodule

`default_nettype wire

/* src/qfs_queue.sv */
`default_nettype none

module qfs_queue
    import qfs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_cmd    i_data,
    input  wire logic    i_pop,
    output t_cmd         o_data,
    output t_queue_status o_status
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_status.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_data         = r_mem[r_rptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* src/qfs_back.sv */
`default_nettype none

module qfs_back
    import qfs_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmd          i_cmd,
    input  wire t_queue_status i_queue,
    output logic               o_pop,
    input  wire logic          i_out_stall,
    output logic               o_out_valid,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_char_out,
    output logic [7:0]         o_field_index,
    output logic [7:0]         o_field_total,
    output logic [2:0]         o_status,
    output logic               o_last
);

    logic       r_valid;
    logic       r_pend;
    logic [7:0] r_pend_total;
    logic [1:0] r_kind;
    logic [7:0] r_char;
    logic [7:0] r_index;
    logic [7:0] r_total;
    logic [2:0] r_status;
    logic       r_last;
    logic       out_free;

    assign out_free = !r_valid || !i_out_stall;
    assign o_pop    = out_free && !r_pend && !i_queue.empty;

    // Control: output valid and pending line-done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (out_free) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (!i_queue.empty) begin
                r_valid <= 1'b1;
                r_pend  <= i_cmd.done_after;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend) begin
                r_kind   <= KIND_DONE;
                r_char   <= '0;
                r_index  <= '0;
                r_total  <= r_pend_total;
                r_status <= ST_OK;
                r_last   <= 1'b1;
            end else if (!i_queue.empty) begin
                r_kind       <= i_cmd.kind;
                r_char       <= i_cmd.char_out;
                r_index      <= i_cmd.field_index;
                r_total      <= i_cmd.done_after ? 8'd0 : i_cmd.field_total;
                r_status     <= i_cmd.status;
                r_last       <= !i_cmd.done_after;
                r_pend_total <= i_cmd.field_total;
            end
        end
    end

    assign o_out_valid   = r_valid;
    assign o_kind        = r_kind;
    assign o_char_out    = r_char;
    assign o_field_index = r_index;
    assign o_field_total = r_total;
    assign o_status      = r_status;
    assign o_last        = r_last;

endmodule

`default_nettype wire

/* src/quoted_field_splitter.sv */
`default_nettype none

// Splits configuration lines into fields, one input character per item.
// The parser takes one item every clock cycle while its four-entry command
// queue has room; items that produce no result (separators, comment text,
// discarded bytes) never enter the queue. The output stage delivers one
// result per cycle unless the receiver stalls; a line ending right after
// a field yields field-end plus line-done from one queue entry. The input
// stalls only when the queue is full, which a run of such lines or a
// stalled receiver can cause. An accepted item's first result passes the
// command queue and then the output register. Register max_fields sits at
// byte address 0 and may only be written while the block is idle.
module quoted_field_splitter
    import qfs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_char_in,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_char_out,
    output logic [7:0]       o_field_index,
    output logic [7:0]       o_field_total,
    output logic [2:0]       o_status,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic          sel_max_fields;
    logic [7:0]    r_max;
    logic          accept;
    logic          push;
    logic          pop;
    t_cmd          push_cmd;
    t_cmd          head_cmd;
    t_queue_status queue_status;

    // Configuration register.
    assign pready = 1'b1;
    assign sel_max_fields = (paddr[2] == REG_MAX_FIELDS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_FIELDS_RESET;
        end else if (psel && penable && pwrite && sel_max_fields) begin
            r_max <= pwdata[7:0];
        end
    end

    assign prdata = sel_max_fields ? {24'd0, r_max} : 32'd0;

    // Input handshake.
    assign o_in_stall = queue_status.full;
    assign accept     = i_in_valid && !o_in_stall;

    qfs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_char       (i_char_in),
        .i_max_fields (r_max),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    qfs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_cmd),
        .i_pop    (pop),
        .o_data   (head_cmd),
        .o_status (queue_status)
    );

    qfs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (head_cmd),
        .i_queue       (queue_status),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_char_out    (o_char_out),
        .o_field_index (o_field_index),
        .o_field_total (o_field_total),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

/* src/qfs_checker.sv */
`default_nettype none

module qfs_checker
    import qfs_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [1:0] o_kind,
    input wire logic [2:0] o_status,
    input wire logic       o_last
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind) && $stable(o_last))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Only a field-end can be followed by another result of the same item.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != KIND_END) |-> o_last)
        else $error("non-final result that is not a field end");

    // Status is nonzero exactly on error results.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_kind == KIND_ERROR) == (o_status != ST_OK)))
        else $error("status does not match kind");

endmodule

bind quoted_field_splitter qfs_checker u_qfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_kind      (o_kind),
    .o_status    (o_status),
    .o_last      (o_last)
);

`default_nettype wire

/* tb/quoted_field_splitter_checker.sv */
`timescale 1ns / 1ps

// Watches the character input, the result output and the register port of
// the field splitter, predicts every result and compares it field by field.
module quoted_field_splitter_checker
    import qfs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [7:0]  i_char_in,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_char_out,
    input  wire logic [7:0]  i_field_index,
    input  wire logic [7:0]  i_field_total,
    input  wire logic [2:0]  i_status,
    input  wire logic        i_last,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic [31:0] i_prdata,
    input  wire logic        i_pready,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results_seen
);

    localparam int         MAX_REPORTS     = 40;
    localparam logic [2:0] ADDR_MAX_FIELDS = {REG_MAX_FIELDS, 2'b00};

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_out;
        logic [7:0] field_index;
        logic [7:0] field_total;
        logic [2:0] status;
        logic       last;
    } t_field_result;

    // Results predicted but not yet delivered, oldest first.
    t_field_result pending_results[$];

    // Shadow copy of the parser state and of the field limit.
    t_mode      parse_mode;
    logic [7:0] field_count;
    logic       quote_has_text;
    logic [7:0] max_fields;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        o_fail_count++;
        if (o_fail_count <= MAX_REPORTS) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end else if (o_fail_count == MAX_REPORTS + 1) begin
            $display("%0t ns: further mismatches are counted but not shown", $time);
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            report_mismatch(what, {24'd0, want}, {24'd0, got});
        end
    endtask

    task automatic add_result(input logic [1:0] kind, input logic [7:0] ch,
                              input logic [7:0] idx, input logic [7:0] total,
                              input logic [2:0] st);
        t_field_result r;
        r = '{kind, ch, idx, total, st, 1'b0};
        pending_results.push_back(r);
    endtask

    task automatic start_line();
        parse_mode     = MODE_BETWEEN;
        field_count    = '0;
        quote_has_text = 1'b0;
    endtask

    // Advances the shadow parser by one character and queues what it emits.
    task automatic split_char(input logic [7:0] c);
        int            prior_size;
        logic          blank;
        t_field_result r;
        prior_size = pending_results.size();
        blank      = (c == CH_SPACE) || (c == CH_TAB);
        case (parse_mode)
            MODE_BETWEEN: begin
                // Separators between fields produce nothing.
                if (!blank) begin
                    if (c == CH_HASH) begin
                        parse_mode = MODE_COMMENT;
                    end else if (c == CH_NUL) begin
                        add_result(KIND_DONE, '0, '0, field_count, ST_OK);
                        start_line();
                    end else if (field_count >= max_fields) begin
                        add_result(KIND_ERROR, '0, field_count, '0, ST_TOO_MANY);
                        parse_mode = MODE_DISCARD;
                    end else if (c == CH_QUOTE) begin
                        quote_has_text = 1'b0;
                        parse_mode     = MODE_QUOTED;
                    end else begin
                        add_result(KIND_CHAR, c, field_count, '0, ST_OK);
                        parse_mode = MODE_BARE;
                    end
                end
            end
            MODE_BARE, MODE_AFTER_QUOTE: begin
                if (blank || c == CH_NUL) begin
                    add_result(KIND_END, '0, field_count, '0, ST_OK);
                    field_count = field_count + 8'd1;
                    parse_mode  = MODE_BETWEEN;
                    if (c == CH_NUL) begin
                        add_result(KIND_DONE, '0, '0, field_count, ST_OK);
                        start_line();
                    end
                end else if (parse_mode == MODE_BARE) begin
                    add_result(KIND_CHAR, c, field_count, '0, ST_OK);
                end else begin
                    // A closing quote must be followed by white space or the line end.
                    add_result(KIND_ERROR, '0, field_count, '0, ST_NO_SPACE);
                    parse_mode = MODE_DISCARD;
                end
            end
            MODE_QUOTED: begin
                if (c == CH_QUOTE) begin
                    if (quote_has_text) begin
                        parse_mode = MODE_AFTER_QUOTE;
                    end else begin
                        add_result(KIND_ERROR, '0, field_count, '0, ST_EMPTY_QUOTE);
                        parse_mode = MODE_DISCARD;
                    end
                end else if (c == CH_BACKSLASH) begin
                    parse_mode = MODE_ESCAPE;
                end else if (c == CH_NUL) begin
                    add_result(KIND_ERROR, '0, field_count, '0, ST_UNTERM);
                    start_line();
                end else begin
                    add_result(KIND_CHAR, c, field_count, '0, ST_OK);
                    quote_has_text = 1'b1;
                end
            end
            MODE_ESCAPE: begin
                if (c == CH_QUOTE || c == CH_BACKSLASH) begin
                    add_result(KIND_CHAR, c, field_count, '0, ST_OK);
                    quote_has_text = 1'b1;
                    parse_mode     = MODE_QUOTED;
                end else if (c == CH_NUL) begin
                    add_result(KIND_ERROR, '0, field_count, '0, ST_UNTERM);
                    start_line();
                end else begin
                    add_result(KIND_ERROR, '0, field_count, '0, ST_BAD_ESCAPE);
                    parse_mode = MODE_DISCARD;
                end
            end
            MODE_COMMENT: begin
                if (c == CH_NUL) begin
                    add_result(KIND_DONE, '0, '0, field_count, ST_OK);
                    start_line();
                end
            end
            default: begin
                // After an error everything up to the line end is dropped.
                if (c == CH_NUL) begin
                    start_line();
                end
            end
        endcase
        // The final result of the item carries the last flag.
        if (pending_results.size() > prior_size) begin
            r      = pending_results.pop_back();
            r.last = 1'b1;
            pending_results.push_back(r);
        end
    endtask

    task automatic compare_result(input t_field_result got);
        t_field_result want;
        if (pending_results.size() == 0) begin
            o_fail_count++;
            $display("%0t ns: result kind %0d index %0d arrived, expected none",
                     $time, got.kind, got.field_index);
        end else begin
            want = pending_results.pop_front();
            check_field("kind", 8'(want.kind), 8'(got.kind));
            check_field("char_out", want.char_out, got.char_out);
            check_field("field_index", want.field_index, got.field_index);
            check_field("field_total", want.field_total, got.field_total);
            check_field("status", 8'(want.status), 8'(got.status));
            check_field("last", 8'(want.last), 8'(got.last));
        end
    endtask

    // Everything is sampled at the rising edge, where the handshakes count.
    always @(posedge i_clk) begin
        t_field_result seen;
        if (!i_rst_n) begin
            start_line();
            max_fields = MAX_FIELDS_RESET;
            pending_results.delete();
            o_fail_count   = 0;
            o_results_seen = 0;
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == ADDR_MAX_FIELDS) begin
                if (i_pwrite) begin
                    max_fields = i_pwdata[7:0];
                end else if (i_prdata !== {24'd0, max_fields}) begin
                    report_mismatch("max_fields readback", {24'd0, max_fields}, i_prdata);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                split_char(i_char_in);
            end
            if (i_out_valid && !i_out_stall) begin
                seen = '{i_kind, i_char_out, i_field_index, i_field_total, i_status, i_last};
                o_results_seen++;
                compare_result(seen);
            end
        end
        o_pending = pending_results.size();
    end

endmodule

/* tb/quoted_field_splitter_tb.sv */
`timescale 1ns / 1ps

module quoted_field_splitter_tb;
    import qfs_pkg::*;

    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         HOLD_CYCLES     = 150;
    localparam int         DRAIN_CYCLES    = 8;
    localparam logic [2:0] ADDR_MAX_FIELDS = {REG_MAX_FIELDS, 2'b00};
    // No register lives here; writes to it must be ignored.
    localparam logic [2:0] ADDR_UNUSED     = 3'd4;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic [7:0]  char_in;
    logic        out_stall;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;

    wire logic        in_stall;
    wire logic        out_valid;
    wire logic [1:0]  kind;
    wire logic [7:0]  char_out;
    wire logic [7:0]  field_index;
    wire logic [7:0]  field_total;
    wire logic [2:0]  status;
    wire logic        last;
    wire logic [31:0] prdata;
    wire logic        pready;

    int fail_count;
    int pending;
    int results_seen;

    int sender_idle_pct   = 8;
    int receiver_idle_pct = 47;
    bit hold_toggle       = 1'b0;
    int items_sent        = 0;
    int lines_sent        = 0;

    quoted_field_splitter i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_char_in     (char_in),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_kind        (kind),
        .o_char_out    (char_out),
        .o_field_index (field_index),
        .o_field_total (field_total),
        .o_status      (status),
        .o_last        (last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    quoted_field_splitter_checker u_field_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_char_in      (char_in),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_kind         (kind),
        .i_char_out     (char_out),
        .i_field_index  (field_index),
        .i_field_total  (field_total),
        .i_status       (status),
        .i_last         (last),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random stalls, or a long hold-off each time hold_toggle flips.
    initial begin
        bit seen_toggle;
        int hold_left;
        out_stall   = 1'b0;
        seen_toggle = 1'b0;
        hold_left   = 0;
        forever begin
            @(posedge clk);
            if (hold_toggle != seen_toggle) begin
                seen_toggle = hold_toggle;
                hold_left   = HOLD_CYCLES;
            end
            @(negedge clk);
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else begin
                out_stall = ($urandom_range(99) < receiver_idle_pct);
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding", CYCLE_LIMIT, pending);
        $display("Regression FAIL");
        $finish;
    end

    // Offers one character, with random idle cycles ahead of it, and returns
    // at the falling edge after it was taken.
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid = 1'b0;
            char_in  = 8'($urandom_range(255));
            @(negedge clk);
        end
        in_valid = 1'b1;
        char_in  = c;
        do @(posedge clk); while (in_stall !== 1'b0);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_line(input logic [7:0] bytes[$]);
        foreach (bytes[k]) begin
            send_char(bytes[k]);
        end
        lines_sent++;
    endtask

    // Stops offering items until every result has arrived and the block has
    // had time to retire items that produce none.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One register access: setup cycle, then access cycle until pready.
    task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    = 1'b1;
        pwrite  = wr;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_max_fields(input logic [7:0] value);
        reg_access(1'b1, ADDR_MAX_FIELDS, {24'd0, value});
        reg_access(1'b0, ADDR_MAX_FIELDS, '0);
    endtask

    // Any byte that has no special meaning to the parser.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(1) ? $urandom_range(8'h21, 8'h7E) : $urandom_range(1, 255));
        end while (b == CH_NUL || b == CH_TAB || b == CH_SPACE || b == CH_HASH ||
                   b == CH_QUOTE || b == CH_BACKSLASH);
        return b;
    endfunction

    // Any byte allowed as literal text inside quotes.
    function automatic logic [7:0] quoted_byte();
        logic [7:0] b;
        if ($urandom_range(9) == 0) begin
            return $urandom_range(1) ? CH_SPACE : CH_TAB;
        end
        do begin
            b = 8'($urandom_range(1, 255));
        end while (b == CH_QUOTE || b == CH_BACKSLASH);
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        return $urandom_range(1) ? CH_SPACE : CH_TAB;
    endfunction

    // Noise leans on the characters the parser reacts to.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(9))
            0:       return CH_TAB;
            1:       return CH_SPACE;
            2:       return CH_HASH;
            3:       return CH_QUOTE;
            4:       return CH_BACKSLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Builds one line: mostly well-formed fields, some broken ones, some noise.
    task automatic random_line(output logic [7:0] line[$]);
        int nfields;
        int f;
        int len;
        line = {};
        if ($urandom_range(99) < 10) begin
            len = $urandom_range(1, 12);
            repeat (len) line.push_back(noise_byte());
            line.push_back(CH_NUL);
            return;
        end
        if ($urandom_range(3) == 0) begin
            line.push_back(blank_byte());
        end
        nfields = $urandom_range(0, 6);
        for (f = 0; f < nfields; f++) begin
            if (f > 0) begin
                repeat ($urandom_range(1, 2)) line.push_back(blank_byte());
            end
            if ($urandom_range(99) < 50) begin
                // Bare field; '#', quote and backslash are plain text after the start.
                line.push_back(plain_byte());
                len = $urandom_range(0, 3);
                repeat (len) begin
                    if ($urandom_range(99) < 15) begin
                        case ($urandom_range(2))
                            0:       line.push_back(CH_HASH);
                            1:       line.push_back(CH_QUOTE);
                            default: line.push_back(CH_BACKSLASH);
                        endcase
                    end else begin
                        line.push_back(plain_byte());
                    end
                end
            end else if ($urandom_range(99) < 80) begin
                // Well-formed quoted field with occasional escapes.
                line.push_back(CH_QUOTE);
                len = $urandom_range(1, 4);
                repeat (len) begin
                    if ($urandom_range(99) < 20) begin
                        line.push_back(CH_BACKSLASH);
                        line.push_back($urandom_range(1) ? CH_QUOTE : CH_BACKSLASH);
                    end else begin
                        line.push_back(quoted_byte());
                    end
                end
                line.push_back(CH_QUOTE);
            end else begin
                // Broken quoted field.
                line.push_back(CH_QUOTE);
                case ($urandom_range(4))
                    0: line.push_back(CH_QUOTE);
                    1: begin
                        line.push_back(quoted_byte());
                        line.push_back(CH_BACKSLASH);
                        line.push_back(quoted_byte());
                    end
                    2: begin
                        line.push_back(quoted_byte());
                        line.push_back(CH_QUOTE);
                        line.push_back($urandom_range(3) == 0 ? CH_HASH : plain_byte());
                    end
                    3: begin
                        line.push_back(quoted_byte());
                        line.push_back(CH_NUL);
                        return;
                    end
                    default: begin
                        line.push_back(CH_BACKSLASH);
                        line.push_back(CH_NUL);
                        return;
                    end
                endcase
            end
        end
        // Optional trailing comment.
        if ($urandom_range(4) == 0) begin
            line.push_back(blank_byte());
            line.push_back(CH_HASH);
            len = $urandom_range(0, 4);
            repeat (len) line.push_back(plain_byte());
        end
        line.push_back(CH_NUL);
    endtask

    task automatic run_random(input int count);
        int         first;
        logic [7:0] line[$];
        first = items_sent;
        while (items_sent - first < count) begin
            random_line(line);
            send_line(line);
        end
    endtask

    initial begin
        logic [7:0] bytes[$];
        int         k;
        in_valid = 1'b0;
        char_in  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        rst_n    = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Reset value of the field limit, then the directed lines: escapes,
        // tab and space separators, a comment, extreme byte values, an empty
        // quote, a quote followed by '#', and a line ending inside an escape.
        reg_access(1'b0, ADDR_MAX_FIELDS, '0);
        bytes = {8'h61, CH_TAB, CH_QUOTE, CH_BACKSLASH, CH_QUOTE, CH_BACKSLASH,
                 CH_BACKSLASH, CH_QUOTE, CH_SPACE, CH_HASH, CH_NUL,
                 8'hFF, 8'h01, CH_NUL,
                 CH_QUOTE, CH_QUOTE, CH_NUL,
                 CH_QUOTE, 8'h71, CH_QUOTE, CH_HASH, CH_NUL,
                 CH_QUOTE, CH_BACKSLASH, CH_NUL};
        send_line(bytes);
        wait_idle();

        // A limit of zero rejects any field, but comments still pass.
        set_max_fields(8'd0);
        bytes = {8'h7A, CH_NUL, CH_TAB, CH_HASH, 8'h78, CH_NUL};
        send_line(bytes);
        wait_idle();

        set_max_fields(8'd1);
        run_random(100);
        wait_idle();

        // Largest limit: a line of 255 one-character fields, then a long
        // receiver hold-off while items keep coming.
        set_max_fields(8'd255);
        bytes = {};
        for (k = 0; k < 255; k++) begin
            if (k > 0) begin
                bytes.push_back(blank_byte());
            end
            bytes.push_back(plain_byte());
        end
        bytes.push_back(CH_NUL);
        send_line(bytes);
        hold_toggle = ~hold_toggle;
        run_random(80);
        wait_idle();
        reg_access(1'b1, ADDR_UNUSED, 32'd1);
        reg_access(1'b0, ADDR_MAX_FIELDS, '0);

        // Swap the idle rates and use a small limit so lines overflow often.
        sender_idle_pct   = 47;
        receiver_idle_pct = 8;
        set_max_fields(8'($urandom_range(2, 6)));
        hold_toggle = ~hold_toggle;
        run_random(150);
        wait_idle();

        // Full rate on both sides.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        set_max_fields(8'($urandom_range(1, 255)));
        run_random(100);
        wait_idle();

        $display("Covered %0d items in %0d lines with %0d results checked,",
                 items_sent, lines_sent, results_seen);
        $display("field limits 8, 0, 1, 255 and two random ones, three idle mixes, two holds.");
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/qfs_pkg.sv
src/qfs_front.sv
src/qfs_queue.sv
src/qfs_back.sv
src/quoted_field_splitter.sv
src/qfs_checker.sv
tb/quoted_field_splitter_checker.sv
tb/quoted_field_splitter_tb.sv
